[src/timed_event_scheduler_core_assert.svh]
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by the checker file only.
`ifndef TIMED_EVENT_SCHEDULER_CORE_ASSERT_SVH
`define TIMED_EVENT_SCHEDULER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TES_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("scheduler check failed");
// Next-cycle implication checked outside reset.
`define TES_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("scheduler check failed");
`endif

[src/tes_pkg.sv]
// Package of the timed event scheduler: operation and result codes, field widths.
// Depends on nothing; used by the top level, its memory module and the checker.
package tes_pkg;
	localparam logic [2:0] OP_AT = 3'd0;
	localparam logic [2:0] OP_AFTER = 3'd1;
	localparam logic [2:0] OP_RECUR = 3'd2;
	localparam logic [2:0] OP_CANCEL = 3'd3;
	localparam logic [2:0] OP_RESCHED = 3'd4;
	localparam logic [2:0] OP_TICK = 3'd5;

	localparam logic [2:0] K_SCHEDULED = 3'd0;
	localparam logic [2:0] K_APPLIED = 3'd1;
	localparam logic [2:0] K_STALE = 3'd2;
	localparam logic [2:0] K_FIRED = 3'd3;
	localparam logic [2:0] K_TICK_END = 3'd4;
	localparam logic [2:0] K_FULL = 3'd5;

	localparam logic [31:0] GEN_FIRST = 32'd1;

	// One table entry as held in memory.
	typedef struct packed {
		logic        repeats;
		logic [31:0] generation;
		logic [63:0] due;
		logic [63:0] period;
		logic [31:0] ev;
		logic [31:0] tg;
	} entry_t;
endpackage

[src/tes_entry_ram.sv]
// Entry table memory of the scheduler: one write port and one registered read port.
// Depends on tes_pkg for the entry type.
module tes_entry_ram import tes_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/timed_event_scheduler_core.sv]
// Top level of the timed event scheduler: command sequencer over an entry memory.
// Depends on tes_pkg and tes_entry_ram.
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// command   | start, busy               | operation, time_value, handle, event_type,
//           |                           | target_system
// result    | strobe (one cycle each)   | kind, handle_out, fired_event, fired_target,
//           |                           | fired_time, pending_total, last
//
// A schedule, cancel or reschedule shows its result from the idle state for a zero or
// out-of-range handle or a full table, from S_SCHW for a fresh slot, from S_CHK after
// S_RD for a handle lookup, and from S_SCHW after S_ALLOC and S_RD for a slot taken
// back from the free stack. A tick scans the table once per fired entry plus once
// more, each scan through the single read port, and each fired entry adds a read
// (S_FRD) and a write back (S_FIRE) before the next scan; the tick-end result
// comes at the end of the final scan.
// Reset clears the live bits, the counters and the current time; no sweep of the memory
// is needed since data of slots at or above the used count is never used.
// The receiver cannot stall: each result is shown for exactly one cycle.
module timed_event_scheduler_core import tes_pkg::*; #(
	parameter int MAX_TIMERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic signed [63:0] time_value,
	input  logic [63:0] handle,
	input  logic [31:0] event_type,
	input  logic [31:0] target_system,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [63:0] handle_out,
	output logic [31:0] fired_event,
	output logic [31:0] fired_target,
	output logic signed [63:0] fired_time,
	output logic [5:0]  pending_total,
	output logic        last
);
	localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_TIMERS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;     // handle lookup read issued, or reused slot's generation back
	localparam logic [3:0] S_CHK = 4'd2;    // read data back, resolve
	localparam logic [3:0] S_ALLOC = 4'd3;  // free stack read back
	localparam logic [3:0] S_SCAN = 4'd4;   // tick scan for earliest due
	localparam logic [3:0] S_FRD = 4'd5;    // read of the chosen entry
	localparam logic [3:0] S_FIRE = 4'd6;   // write back and emit fired
	localparam logic [3:0] S_SCHW = 4'd7;   // write new entry

	logic [3:0] state_q;
	logic [63:0] now_q;
	logic [MAX_TIMERS-1:0] live_q, done_q;
	logic [CW-1:0] free_depth_q, slots_used_q, live_count_q;
	logic [2:0] op_q;
	logic [63:0] tv_q, h_q;
	logic [31:0] ev_q, tg_q;
	logic [AW-1:0] slot_q;
	logic [31:0] gen_q;

	// Free stack: small memory with registered read.
	logic [AW-1:0] fstack [MAX_TIMERS];
	logic [AW-1:0] fs_rd_q;
	logic fs_we;
	logic [AW-1:0] fs_waddr, fs_wdata, fs_raddr;

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fstack[fs_waddr] <= fs_wdata;
		end
		fs_rd_q <= fstack[fs_raddr];
	end

	// Entry memory.
	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	tes_entry_ram #(.DEPTH(MAX_TIMERS), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Scan bookkeeping: index being issued, index whose data is back, best so far.
	logic [CW:0] scan_q;
	logic [AW-1:0] chk_idx_q;
	logic chk_v_q;
	logic best_v_q;
	logic [AW-1:0] best_q;
	logic [63:0] best_due_q;

	logic signed [63:0] rd_due_s, best_s, now_s;
	logic cand;
	assign rd_due_s = rdata.due;
	assign best_s = best_due_q;
	assign now_s = now_q;
	assign cand = chk_v_q && live_q[chk_idx_q] && !done_q[chk_idx_q]
		&& (CW'(chk_idx_q) < slots_used_q) && (rd_due_s <= now_s)
		&& (!best_v_q || rd_due_s < best_s);

	logic [63:0] hnd_gen_slot;
	assign hnd_gen_slot = {32'd0, handle[31:0]};

	assign busy = (state_q != S_IDLE);

	// Memory addressing per state. A slot taken from the free stack is read while
	// the stack output is still in hand, so its generation is back in S_RD.
	always_comb begin
		raddr = slot_q;
		fs_raddr = AW'(free_depth_q - CW'(1));
		if (state_q == S_SCAN) begin
			raddr = scan_q[AW-1:0];
		end else if (state_q == S_FRD) begin
			raddr = best_q;
		end else if (state_q == S_ALLOC) begin
			raddr = fs_rd_q;
		end
	end

	logic [31:0] gen_bump;
	assign gen_bump = (rdata.generation == 32'hFFFF_FFFF) ? GEN_FIRST
		: rdata.generation + 32'd1;

	always_comb begin
		we = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		fs_we = 1'b0;
		fs_waddr = AW'(free_depth_q);
		fs_wdata = slot_q;
		if (state_q == S_SCHW) begin
			we = 1'b1;
			wdata.repeats = (op_q == OP_RECUR);
			wdata.generation = gen_q;
			wdata.due = (op_q == OP_AT) ? tv_q : now_q + tv_q;
			wdata.period = (op_q == OP_RECUR) ? tv_q : 64'd0;
			wdata.ev = ev_q;
			wdata.tg = tg_q;
		end else if (state_q == S_CHK && op_q == OP_RESCHED) begin
			wdata.due = tv_q;
			we = 1'b1;
		end else if (state_q == S_CHK) begin
			wdata.repeats = 1'b0;
			wdata.period = 64'd0;
			wdata.generation = gen_bump;
			we = 1'b1;
			fs_we = (free_depth_q < MAXC);
		end else if (state_q == S_FIRE) begin
			we = 1'b1;
			waddr = best_q;
			fs_waddr = AW'(free_depth_q);
			fs_wdata = best_q;
			if (rdata.repeats) begin
				wdata.due = rdata.due + rdata.period;
			end else begin
				wdata.repeats = 1'b0;
				wdata.period = 64'd0;
				wdata.generation = gen_bump;
				fs_we = (free_depth_q < MAXC);
			end
		end
		// Writes from the check state only count when the handle resolved.
		if (state_q == S_CHK && !(live_q[slot_q] && rdata.generation == h_q[63:32])) begin
			we = 1'b0;
			fs_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= '0;
			live_q <= '0;
			done_q <= '0;
			free_depth_q <= '0;
			slots_used_q <= '0;
			live_count_q <= '0;
			strobe <= 1'b0;
			scan_q <= '0;
			chk_v_q <= 1'b0;
			best_v_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						tv_q <= time_value;
						h_q <= handle;
						ev_q <= event_type;
						tg_q <= target_system;
						slot_q <= handle[AW-1:0];
						if (operation == OP_CANCEL || operation == OP_RESCHED) begin
							if (handle == 64'd0 || hnd_gen_slot >= 64'(slots_used_q)) begin
								strobe <= 1'b1;
								kind <= K_STALE;
								handle_out <= '0;
								fired_event <= '0;
								fired_target <= '0;
								fired_time <= '0;
								pending_total <= 6'(live_count_q);
								last <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end else if (operation == OP_TICK) begin
							now_q <= time_value;
							done_q <= '0;
							scan_q <= '0;
							chk_v_q <= 1'b0;
							best_v_q <= 1'b0;
							state_q <= S_SCAN;
						end else if (operation == OP_AT || operation == OP_AFTER
								|| operation == OP_RECUR) begin
							if (free_depth_q != '0) begin
								state_q <= S_ALLOC;
							end else if (slots_used_q < MAXC) begin
								slot_q <= AW'(slots_used_q);
								gen_q <= GEN_FIRST;
								slots_used_q <= slots_used_q + CW'(1);
								state_q <= S_SCHW;
							end else begin
								strobe <= 1'b1;
								kind <= K_FULL;
								handle_out <= '0;
								fired_event <= '0;
								fired_target <= '0;
								fired_time <= '0;
								pending_total <= 6'(live_count_q);
								last <= 1'b1;
							end
						end
					end
				end
				S_ALLOC: begin
					slot_q <= fs_rd_q;
					free_depth_q <= free_depth_q - CW'(1);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= (op_q == OP_CANCEL || op_q == OP_RESCHED) ? S_CHK : S_SCHW;
				end
				S_SCHW: begin
					live_q[slot_q] <= 1'b1;
					live_count_q <= live_count_q + CW'(1);
					strobe <= 1'b1;
					kind <= K_SCHEDULED;
					handle_out <= {gen_q, 32'(slot_q)};
					fired_event <= '0;
					fired_target <= '0;
					fired_time <= '0;
					pending_total <= 6'(live_count_q + CW'(1));
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CHK: begin
					strobe <= 1'b1;
					handle_out <= '0;
					fired_event <= '0;
					fired_target <= '0;
					fired_time <= '0;
					last <= 1'b1;
					pending_total <= 6'(live_count_q);
					state_q <= S_IDLE;
					if (live_q[slot_q] && rdata.generation == h_q[63:32]) begin
						kind <= K_APPLIED;
						if (op_q == OP_CANCEL) begin
							live_q[slot_q] <= 1'b0;
							live_count_q <= live_count_q - CW'(1);
							pending_total <= 6'(live_count_q - CW'(1));
							if (free_depth_q < MAXC) begin
								free_depth_q <= free_depth_q + CW'(1);
							end
						end
					end else begin
						kind <= K_STALE;
					end
				end
				S_SCAN: begin
					chk_v_q <= (scan_q < (CW+1)'(MAX_TIMERS));
					chk_idx_q <= scan_q[AW-1:0];
					if (cand) begin
						best_v_q <= 1'b1;
						best_q <= chk_idx_q;
						best_due_q <= rdata.due;
					end
					if (scan_q == (CW+1)'(MAX_TIMERS)) begin
						scan_q <= scan_q + 1'b1;
					end else if (scan_q > (CW+1)'(MAX_TIMERS)) begin
						// Last comparison folded in above on this cycle.
						if (best_v_q || cand) begin
							state_q <= S_FRD;
						end else begin
							strobe <= 1'b1;
							kind <= K_TICK_END;
							handle_out <= '0;
							fired_event <= '0;
							fired_target <= '0;
							fired_time <= '0;
							pending_total <= 6'(live_count_q);
							last <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FRD: begin
					state_q <= S_FIRE;
				end
				S_FIRE: begin
					done_q[best_q] <= 1'b1;
					strobe <= 1'b1;
					kind <= K_FIRED;
					handle_out <= {rdata.generation, 32'(best_q)};
					fired_event <= rdata.ev;
					fired_target <= rdata.tg;
					fired_time <= rdata.due;
					last <= 1'b0;
					pending_total <= 6'(live_count_q);
					if (!rdata.repeats) begin
						live_q[best_q] <= 1'b0;
						live_count_q <= live_count_q - CW'(1);
						pending_total <= 6'(live_count_q - CW'(1));
						if (free_depth_q < MAXC) begin
							free_depth_q <= free_depth_q + CW'(1);
						end
					end
					scan_q <= '0;
					chk_v_q <= 1'b0;
					best_v_q <= 1'b0;
					state_q <= S_SCAN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A reused slot keeps its generation from memory.
			if (state_q == S_RD && op_q != OP_CANCEL && op_q != OP_RESCHED) begin
				gen_q <= rdata.generation;
			end
		end
	end
endmodule

[src/tes_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
// Depends on timed_event_scheduler_core_assert.svh and tes_pkg for the result codes.
`include "timed_event_scheduler_core_assert.svh"
module tes_checker import tes_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       strobe,
	input logic [2:0] kind,
	input logic       last,
	input logic [5:0] pending_total
);
	`TES_ASSERT_IMP(a_fired_not_last, clk, arst_n, strobe && kind == K_FIRED, !last)
	`TES_ASSERT_IMP(a_end_is_last, clk, arst_n, strobe && kind != K_FIRED, last)
	`TES_ASSERT_IMP(a_pending_range, clk, arst_n, strobe, pending_total <= 6'd32)
	`TES_ASSERT_IMP(a_last_frees, clk, arst_n, strobe && last, !busy)
	`TES_ASSERT_NXT(a_fired_busy, clk, arst_n, strobe && kind == K_FIRED, busy)
endmodule

bind timed_event_scheduler_core tes_checker u_tes_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .strobe(strobe),
	.kind(kind), .last(last), .pending_total(pending_total)
);
